/* hw/rtl/itp_pkg.sv */
// Shared types, character codes and helpers for the infix to postfix converter.
package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_DIG_LO = 8'h30;
   localparam logic [7:0] CH_DIG_HI = 8'h39;
   localparam logic [7:0] CH_LET_LO = 8'h61;
   localparam logic [7:0] CH_LET_HI = 8'h7A;

   typedef enum logic [2:0] {
      CLS_OPERAND,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_OP,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      logic [7:0] ch;
      cls_type    cls;
      logic [1:0] prec;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       ovf;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_BODY,
      ST_END_SPACE,
      ST_END_POP,
      ST_DONE
   } state_type;

   function automatic logic [1:0] char_prec(input logic [7:0] c);
      logic [1:0] p;
      case (c) inside
         CH_EQ:                     p = 2'd1;
         CH_PLUS, CH_MINUS:         p = 2'd2;
         CH_STAR, CH_SLASH, CH_PCT: p = 2'd3;
         default:                   p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic cls_type classify(input logic [7:0] c);
      cls_type k;
      case (c) inside
         [CH_DIG_LO:CH_DIG_HI], [CH_LET_LO:CH_LET_HI]:  k = CLS_OPERAND;
         CH_LPAREN:                                     k = CLS_OPEN;
         CH_RPAREN:                                     k = CLS_CLOSE;
         CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT,
         CH_EQ:                                         k = CLS_OP;
         default:                                       k = CLS_OTHER;
      endcase
      return k;
   endfunction

endpackage

/* hw/rtl/infix_to_postfix_converter.sv */
// Top level of the infix to postfix converter.
// Infix characters go in as words on the req_ side; postfix characters come out as words on
// the rsp_ side, the last word of each input word flagged by rsp_run_last. A word on the
// req_ side is classified on acceptance and waits in a two-entry queue; the back end's
// sequencer then converts it, making one stack access and producing at most one result
// word per cycle, and pops operators off the stack as the precedence rules call for.
// Expression end emits a space if an operand run is open, flushes the stack and adds a
// terminating NUL. A full result queue holds the sequencer for as long as it stays full.
// The operator stack holds STACK_DEPTH entries; pushes beyond that are dropped and raise
// rsp_overflowed until the expression ends. No clearing pass is needed after reset.
module infix_to_postfix_converter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_char,
   input  logic       req_expression_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last,
   output logic       rsp_overflowed
);
   import itp_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_head;

   itp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_in_char        (req_in_char),
      .req_expression_end (req_expression_end),
      .cmd_valid          (cmd_valid),
      .cmd_head           (cmd_head),
      .cmd_pop            (cmd_pop)
   );

   itp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_head       (cmd_head),
      .cmd_pop        (cmd_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule

/* hw/rtl/itp_front.sv */
// Front end: accepts input words, classifies them and queues commands for the back end.
module itp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_in_char,
   input  logic             req_expression_end,
   output logic             cmd_valid,
   output itp_pkg::cmd_type cmd_head,
   input  logic             cmd_pop
);
   import itp_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;
   cmd_type    new_cmd;

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_head  = q_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.ch   = req_in_char;
      new_cmd.cls  = classify(req_in_char);
      new_cmd.prec = char_prec(req_in_char);
      new_cmd.last = req_expression_end;
      do_push   = req_push && !req_full;
      do_pop    = cmd_pop && cmd_valid;
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* hw/rtl/itp_back.sv */
// Back end: operator stack sequencer and result queue.
module itp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  itp_pkg::cmd_type cmd_head,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   output logic             rsp_overflowed
);
   import itp_pkg::*;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_dec;
   logic              run_ff, run_in;
   logic              ovf_ff, ovf_in;

   logic [7:0]        mem [STACK_DEPTH];
   logic [7:0]        top_ff;
   logic              we;
   logic [ADDR_W-1:0] waddr, raddr;

   logic              hold_v_ff;
   logic [7:0]        hold_ch_ff;
   logic              hold_ovf_ff;

   rsp_type           oq_ff [2];
   logic              oq_wr_ff, oq_rd_ff;
   logic [1:0]        oq_cnt_ff;
   logic              oq_full, oq_push, oq_pop;
   rsp_type           oq_wdata;

   logic              emit, can_emit, flush_last;
   logic [7:0]        emit_ch;
   logic              stack_full, stack_empty, top_wins;
   state_type         after_body;

   assign stack_full  = (cnt_ff == CNT_W'(STACK_DEPTH));
   assign stack_empty = (cnt_ff == '0);
   assign top_wins    = !stack_empty && (char_prec(top_ff) >= cmd_ff.prec);
   assign cnt_dec     = cnt_ff - CNT_W'(1);
   assign after_body  = cmd_ff.last ? ST_END_SPACE : ST_DONE;
   assign oq_full     = (oq_cnt_ff == 2'd2);
   assign can_emit    = !hold_v_ff || !oq_full;
   assign waddr       = cnt_ff[ADDR_W-1:0];

   always_comb begin
      logic [CNT_W-1:0] rd_idx;
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      cnt_in     = cnt_ff;
      run_in     = run_ff;
      ovf_in     = ovf_ff;
      we         = 1'b0;
      emit       = 1'b0;
      emit_ch    = CH_NUL;
      flush_last = 1'b0;
      cmd_pop    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_head;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (cmd_ff.cls == CLS_OPERAND) begin
               emit    = 1'b1;
               emit_ch = cmd_ff.ch;
               if (can_emit) begin
                  run_in   = 1'b1;
                  state_in = after_body;
               end
            end else if (run_ff) begin
               emit    = 1'b1;
               emit_ch = CH_SPACE;
               if (can_emit) begin
                  run_in   = 1'b0;
                  state_in = ST_BODY;
               end
            end else begin
               state_in = ST_BODY;
            end
         end
         ST_BODY: begin
            case (cmd_ff.cls)
               CLS_OPEN: begin
                  if (stack_full) begin
                     ovf_in = 1'b1;
                  end else begin
                     we     = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
                  state_in = after_body;
               end
               CLS_CLOSE: begin
                  if (stack_empty) begin
                     state_in = after_body;
                  end else if (top_ff == CH_LPAREN) begin
                     cnt_in   = cnt_dec;
                     state_in = after_body;
                  end else begin
                     emit    = 1'b1;
                     emit_ch = top_ff;
                     if (can_emit) begin
                        cnt_in = cnt_dec;
                     end
                  end
               end
               CLS_OP: begin
                  if (top_wins) begin
                     emit    = 1'b1;
                     emit_ch = top_ff;
                     if (can_emit) begin
                        cnt_in = cnt_dec;
                     end
                  end else begin
                     if (stack_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        we     = 1'b1;
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                     state_in = after_body;
                  end
               end
               default: begin
                  state_in = after_body;
               end
            endcase
         end
         ST_END_SPACE: begin
            if (run_ff) begin
               emit    = 1'b1;
               emit_ch = CH_SPACE;
               if (can_emit) begin
                  run_in   = 1'b0;
                  state_in = ST_END_POP;
               end
            end else begin
               state_in = ST_END_POP;
            end
         end
         ST_END_POP: begin
            emit = 1'b1;
            if (!stack_empty) begin
               emit_ch = top_ff;
               if (can_emit) begin
                  cnt_in = cnt_dec;
               end
            end else begin
               emit_ch = CH_NUL;
               if (can_emit) begin
                  ovf_in   = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // mark the held word as the item's last and release it
            if (!hold_v_ff) begin
               state_in = ST_IDLE;
            end else if (!oq_full) begin
               flush_last = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rd_idx = cnt_in - CNT_W'(1);
      raddr  = rd_idx[ADDR_W-1:0];
   end

   assign oq_push        = (emit && can_emit && hold_v_ff) || flush_last;
   assign oq_pop         = rsp_pop && !rsp_empty;
   assign oq_wdata.ch    = hold_ch_ff;
   assign oq_wdata.ovf   = hold_ovf_ff;
   assign oq_wdata.last  = flush_last;
   assign rsp_empty      = (oq_cnt_ff == 2'd0);
   assign rsp_out_char   = oq_ff[oq_rd_ff].ch;
   assign rsp_run_last   = oq_ff[oq_rd_ff].last;
   assign rsp_overflowed = oq_ff[oq_rd_ff].ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         run_ff    <= 1'b0;
         ovf_ff    <= 1'b0;
         hold_v_ff <= 1'b0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         run_ff    <= run_in;
         ovf_ff    <= ovf_in;
         if (emit && can_emit) begin
            hold_v_ff <= 1'b1;
         end else if (flush_last) begin
            hold_v_ff <= 1'b0;
         end
         if (oq_push) begin
            oq_wr_ff <= ~oq_wr_ff;
         end
         if (oq_pop) begin
            oq_rd_ff <= ~oq_rd_ff;
         end
         oq_cnt_ff <= oq_cnt_ff + {1'b0, oq_push} - {1'b0, oq_pop};
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit && can_emit) begin
         hold_ch_ff  <= emit_ch;
         hold_ovf_ff <= ovf_ff;
      end
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= oq_wdata;
      end
   end

   // stack storage; top_ff always tracks the entry below the next count
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= cmd_ff.ch;
      end
      if (we && (waddr == raddr)) begin
         top_ff <= cmd_ff.ch;
      end else begin
         top_ff <= mem[raddr];
      end
   end

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the infix to postfix converter: random expressions vs. a predictor.
`timescale 1ns / 1ps

module tb_top;
   import itp_pkg::*;

   localparam int CLK_HALF = 10;
   localparam int ITEM_TARGET = 260;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER = 150;
   localparam int DRAIN_CYCLES = 60;

   localparam logic [7:0] OPERATORS[6] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_EQ};
   localparam logic [7:0] NEAR_MISSES[8] = '{8'h3A, 8'h40, 8'h5A, 8'h60, 8'h7B, 8'h7F, 8'h80,
                                             CH_SPACE};

   // Opening words: {expression_end, in_char}
   localparam logic [8:0] OPENING[25] = '{
      {1'b0, CH_LET_LO}, {1'b0, CH_PLUS}, {1'b0, 8'h62}, {1'b0, CH_STAR}, {1'b1, 8'h63},
      {1'b0, CH_LPAREN}, {1'b0, CH_DIG_HI}, {1'b0, CH_MINUS}, {1'b0, CH_LET_HI},
      {1'b0, CH_RPAREN}, {1'b0, CH_SLASH}, {1'b0, CH_DIG_LO}, {1'b0, CH_PCT}, {1'b0, 8'h38},
      {1'b0, CH_EQ}, {1'b1, 8'h79},
      {1'b0, CH_RPAREN},
      {1'b0, 8'h6B}, {1'b0, CH_PLUS}, {1'b0, 8'h6D}, {1'b0, CH_RPAREN},
      {1'b0, 8'hFF}, {1'b0, 8'h71}, {1'b0, CH_NUL}, {1'b1, CH_LPAREN}
   };

   class postfix_tracker;
      rsp_type    postfix_due[$];
      logic [7:0] op_stack[STACK_DEPTH];
      int         stack_fill;
      bit         run_open;
      bit         ovf_flag;
      int         failures;
      int         words_checked;

      function bit is_operand(logic [7:0] c);
         return (c >= CH_DIG_LO && c <= CH_DIG_HI) || (c >= CH_LET_LO && c <= CH_LET_HI);
      endfunction

      function bit is_operator(logic [7:0] c);
         return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                c == CH_PCT || c == CH_EQ;
      endfunction

      function int rank(logic [7:0] c);
         if (c == CH_EQ) return 1;
         if (c == CH_PLUS || c == CH_MINUS) return 2;
         if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) return 3;
         return 0;
      endfunction

      function void put(logic [7:0] c);
         rsp_type w;
         w.ch = c;
         w.last = 1'b0;
         w.ovf = ovf_flag;
         postfix_due.push_back(w);
      endfunction

      function void pop_top();
         put(op_stack[stack_fill - 1]);
         stack_fill--;
      endfunction

      function void stack_push(logic [7:0] c);
         if (stack_fill >= STACK_DEPTH) begin
            ovf_flag = 1'b1;
         end else begin
            op_stack[stack_fill] = c;
            stack_fill++;
         end
      endfunction

      // Convert one accepted word and queue the postfix words it produces.
      function void note_word(logic [7:0] c, logic fin);
         int mark;
         rsp_type w;
         mark = postfix_due.size();
         if (is_operand(c)) begin
            put(c);
            run_open = 1'b1;
         end else begin
            if (run_open) begin
               put(CH_SPACE);
               run_open = 1'b0;
            end
            if (c == CH_LPAREN) begin
               stack_push(c);
            end else if (c == CH_RPAREN) begin
               while (stack_fill > 0 && op_stack[stack_fill - 1] != CH_LPAREN) pop_top();
               // drop the matching open paren
               if (stack_fill > 0) stack_fill--;
            end else if (is_operator(c)) begin
               while (stack_fill > 0 && rank(op_stack[stack_fill - 1]) >= rank(c)) pop_top();
               stack_push(c);
            end
         end
         if (fin) begin
            if (run_open) begin
               put(CH_SPACE);
               run_open = 1'b0;
            end
            while (stack_fill > 0) pop_top();
            put(CH_NUL);
            ovf_flag = 1'b0;
         end
         if (postfix_due.size() > mark) begin
            w = postfix_due.pop_back();
            w.last = 1'b1;
            postfix_due.push_back(w);
         end
      endfunction

      task report(string what, logic [7:0] got, logic [7:0] want);
         $display("mismatch on %s: got %h, expected %h (word %0d)", what, got, want,
                  words_checked);
         failures++;
      endtask

      task check_word(logic [7:0] ch, logic last, logic ovf);
         rsp_type w;
         words_checked++;
         if (postfix_due.size() == 0) begin
            report("unexpected word", ch, 8'h00);
         end else begin
            w = postfix_due.pop_front();
            if (ch !== w.ch) report("out_char", ch, w.ch);
            if (last !== w.last) report("run_last", 8'(last), 8'(w.last));
            if (ovf !== w.ovf) report("overflowed", 8'(ovf), 8'(w.ovf));
         end
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_in_char;
   logic       req_expression_end;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_char;
   logic       rsp_run_last;
   logic       rsp_overflowed;

   postfix_tracker tracker = new();
   logic [7:0]     infix_chars[$];
   int             items_sent;
   int             phase;

   infix_to_postfix_converter dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_in_char        (req_in_char),
      .req_expression_end (req_expression_end),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_out_char       (rsp_out_char),
      .rsp_run_last       (rsp_run_last),
      .rsp_overflowed     (rsp_overflowed)
   );

   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   function automatic logic [7:0] operand_char();
      if ($urandom_range(0, 1) == 0) return CH_DIG_LO + 8'($urandom_range(0, 9));
      return CH_LET_LO + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] noise_char();
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      return NEAR_MISSES[$urandom_range(0, 7)];
   endfunction

   task automatic send_word(input logic [7:0] ch, input logic fin);
      int gap_pct;
      phase = (items_sent < 90) ? 0 : (items_sent < 180) ? 1 : 2;
      gap_pct = (phase == 0) ? 23 : (phase == 1) ? 49 : 0;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_in_char <= ch;
      req_expression_end <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      tracker.note_word(ch, fin);
      items_sent++;
   endtask

   // Fill infix_chars with one expression; deep ones open with 31 to 34 parens, which can overrun the operator stack.
   task automatic build_expression(input bit deep);
      int terms;
      int open_parens;
      infix_chars.delete();
      open_parens = 0;
      if (deep) repeat ($urandom_range(31, 34)) infix_chars.push_back(CH_LPAREN);
      terms = $urandom_range(1, 6);
      for (int t = 0; t < terms; t++) begin
         while ($urandom_range(0, 3) == 0) begin
            infix_chars.push_back(CH_LPAREN);
            open_parens++;
         end
         repeat ($urandom_range(1, 3)) infix_chars.push_back(operand_char());
         while (open_parens > 0 && $urandom_range(0, 2) == 0) begin
            infix_chars.push_back(CH_RPAREN);
            open_parens--;
         end
         if ($urandom_range(0, 9) == 0) infix_chars.push_back(noise_char());
         if (t < terms - 1) infix_chars.push_back(OPERATORS[$urandom_range(0, 5)]);
      end
      if ($urandom_range(0, 4) != 0) repeat (open_parens) infix_chars.push_back(CH_RPAREN);
      // break the tail now and then
      if ($urandom_range(0, 5) == 0) begin
         case ($urandom_range(0, 3))
            0: infix_chars.push_back(OPERATORS[$urandom_range(0, 5)]);
            1: infix_chars.push_back(CH_RPAREN);
            2: infix_chars.push_back(CH_LPAREN);
            default: infix_chars.push_back(noise_char());
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         tracker.check_word(rsp_out_char, rsp_run_last, rsp_overflowed);
   end

   initial begin : drain
      int stall_pct;
      bit held;
      held = 1'b0;
      rsp_pop <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         // hold off long enough for the block to back up into its input
         if (!held && tracker.words_checked >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall_pct = (phase == 0) ? 49 : (phase == 1) ? 23 : 0;
         rsp_pop <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin : stimulus
      int expr_no;
      int k;
      items_sent = 0;
      phase = 0;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_in_char <= CH_NUL;
      req_expression_end <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (OPENING[i]) send_word(OPENING[i][7:0], OPENING[i][8]);
      expr_no = 0;
      while (items_sent < ITEM_TARGET) begin
         build_expression(expr_no == 1 || expr_no == 4);
         for (k = 0; k < infix_chars.size(); k++)
            send_word(infix_chars[k], k == infix_chars.size() - 1);
         expr_no++;
      end
      req_push <= 1'b0;
      while (tracker.postfix_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      #(200_000 * 2 * CLK_HALF);
      $display("tb: failure");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/itp_pkg.sv
hw/rtl/itp_front.sv
hw/rtl/itp_back.sv
hw/rtl/infix_to_postfix_converter.sv
bench/tb_top.sv
